>>> hdl/mmb_pkg.sv
package mmb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ANG_FRAC  = 24;
	localparam int TRIG_FRAC = 30;
	localparam int STEPS     = 24;
	localparam int TW        = 32;
	localparam int RW        = 34;
	localparam int AW        = 36;
	localparam int DW        = 32;
	localparam int ANG_W     = 26;
	localparam int QDEPTH    = 16;
	localparam int QAW       = 4;
	localparam int QCW       = 5;

	localparam logic signed [AW-1:0] FULL  = 36'sd6039797760;
	localparam logic signed [AW-1:0] HALF  = 36'sd3019898880;
	localparam logic signed [AW-1:0] QUART = 36'sd1509949440;
	localparam logic signed [TW-1:0] CORDIC_K = 32'sd652032874;

	typedef struct packed {
		logic [DW-1:0]              scale;
		logic [2:0][ANG_W-1:0]      angle;
		logic [2:0][DW-1:0]         trans;
	} item_t;

	typedef struct packed {
		logic [8:0][RW-1:0]         r;
		logic [2:0][DW-1:0]         trans;
		logic [DW-1:0]              scale;
	} entry_t;

	function automatic logic signed [RW-1:0] atan_deg(input logic [4:0] i);
		logic signed [RW-1:0] v;
		unique case (i)
			5'd0:  v = 34'sd754974720;
			5'd1:  v = 34'sd445687602;
			5'd2:  v = 34'sd235489088;
			5'd3:  v = 34'sd119537938;
			5'd4:  v = 34'sd60000934;
			5'd5:  v = 34'sd30029717;
			5'd6:  v = 34'sd15018523;
			5'd7:  v = 34'sd7509720;
			5'd8:  v = 34'sd3754917;
			5'd9:  v = 34'sd1877466;
			5'd10: v = 34'sd938734;
			5'd11: v = 34'sd469367;
			5'd12: v = 34'sd234684;
			5'd13: v = 34'sd117342;
			5'd14: v = 34'sd58671;
			5'd15: v = 34'sd29335;
			5'd16: v = 34'sd14668;
			5'd17: v = 34'sd7334;
			5'd18: v = 34'sd3667;
			5'd19: v = 34'sd1833;
			5'd20: v = 34'sd917;
			5'd21: v = 34'sd458;
			5'd22: v = 34'sd229;
			5'd23: v = 34'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [RW-1:0] qmul(input logic signed [RW-1:0] a,
			input logic signed [RW-1:0] b);
		logic signed [2*RW-1:0] rnd;
		logic signed [2*RW-1:0] p;
		rnd = '0;
		rnd[TRIG_FRAC-1] = 1'b1;
		p = a * b;
		p = p + rnd;
		return p[TRIG_FRAC +: RW];
	endfunction

endpackage

>>> hdl/mmb_front.sv
module mmb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  mmb_pkg::item_t      in_item,
	output logic                out_valid,
	output mmb_pkg::entry_t     out_entry
);

	localparam int NS = mmb_pkg::STEPS;
	localparam int RW = mmb_pkg::RW;
	localparam int AW = mmb_pkg::AW;
	localparam int TW = mmb_pkg::TW;

	logic                 v1_q;
	mmb_pkg::item_t       it1_q;
	logic signed [AW-1:0] a1_q [0:2];
	logic signed [AW-1:0] wr   [0:2];

	logic                 vld_q [0:NS];
	mmb_pkg::item_t       it_q  [0:NS];
	logic signed [TW-1:0] cx_q  [0:NS][0:2];
	logic signed [TW-1:0] cy_q  [0:NS][0:2];
	logic signed [RW-1:0] cz_q  [0:NS][0:2];
	logic [2:0]           neg_q [0:NS];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			wr[l] = AW'($signed(in_item.angle[l]));
			wr[l] = wr[l] <<< (mmb_pkg::ANG_FRAC - mmb_pkg::FRAC_BITS);
			if (wr[l] >= mmb_pkg::FULL) begin
				wr[l] = wr[l] - mmb_pkg::FULL;
			end else if (wr[l] <= -mmb_pkg::FULL) begin
				wr[l] = wr[l] + mmb_pkg::FULL;
			end
			if (wr[l] >= mmb_pkg::HALF) begin
				wr[l] = wr[l] - mmb_pkg::FULL;
			end else if (wr[l] < -mmb_pkg::HALF) begin
				wr[l] = wr[l] + mmb_pkg::FULL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q     <= 1'b0;
			vld_q[0] <= 1'b0;
		end else begin
			v1_q     <= in_valid;
			vld_q[0] <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		it1_q    <= in_item;
		it_q[0]  <= it1_q;
		for (int l = 0; l < 3; l++) begin
			a1_q[l]     <= wr[l];
			cx_q[0][l]  <= mmb_pkg::CORDIC_K;
			cy_q[0][l]  <= '0;
			if (a1_q[l] > mmb_pkg::QUART) begin
				cz_q[0][l]   <= RW'(mmb_pkg::HALF - a1_q[l]);
				neg_q[0][l]  <= 1'b1;
			end else if (a1_q[l] < -mmb_pkg::QUART) begin
				cz_q[0][l]   <= RW'(-mmb_pkg::HALF - a1_q[l]);
				neg_q[0][l]  <= 1'b1;
			end else begin
				cz_q[0][l]   <= RW'(a1_q[l]);
				neg_q[0][l]  <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else begin
				vld_q[i+1] <= vld_q[i];
			end
		end
		always_ff @(posedge clk) begin
			it_q[i+1]  <= it_q[i];
			neg_q[i+1] <= neg_q[i];
			for (int l = 0; l < 3; l++) begin
				if (!cz_q[i][l][RW-1]) begin
					cx_q[i+1][l] <= cx_q[i][l] - (cy_q[i][l] >>> i);
					cy_q[i+1][l] <= cy_q[i][l] + (cx_q[i][l] >>> i);
					cz_q[i+1][l] <= cz_q[i][l] - mmb_pkg::atan_deg(5'(i));
				end else begin
					cx_q[i+1][l] <= cx_q[i][l] + (cy_q[i][l] >>> i);
					cy_q[i+1][l] <= cy_q[i][l] - (cx_q[i][l] >>> i);
					cz_q[i+1][l] <= cz_q[i][l] + mmb_pkg::atan_deg(5'(i));
				end
			end
		end
	end

	logic signed [RW-1:0] cv [0:2];
	logic signed [RW-1:0] sv [0:2];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			cv[l] = neg_q[NS][l] ? -RW'(cx_q[NS][l]) : RW'(cx_q[NS][l]);
			sv[l] = RW'(cy_q[NS][l]);
		end
	end

	logic                 vm1_s1, vm2_s2, vm3_s3;
	mmb_pkg::item_t       it_s1, it_s2;
	logic signed [RW-1:0] czsy_s1, szsy_s1, czcy_s1, szcx_s1, szsx_s1, szcy_s1;
	logic signed [RW-1:0] czcx_s1, czsx_s1, cysx_s1, cycx_s1, sx_s1, cx_s1, nsy_s1;
	logic signed [RW-1:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [RW-1:0] szcx_s2, szsx_s2, czcx_s2, czsx_s2;
	logic signed [RW-1:0] czcy_s2, szcy_s2, cysx_s2, cycx_s2, nsy_s2;
	mmb_pkg::entry_t      ent_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm1_s1 <= 1'b0;
			vm2_s2 <= 1'b0;
			vm3_s3 <= 1'b0;
		end else begin
			vm1_s1 <= vld_q[NS];
			vm2_s2 <= vm1_s1;
			vm3_s3 <= vm2_s2;
		end
	end

	always_ff @(posedge clk) begin
		it_s1   <= it_q[NS];
		czsy_s1 <= mmb_pkg::qmul(cv[2], sv[1]);
		szsy_s1 <= mmb_pkg::qmul(sv[2], sv[1]);
		czcy_s1 <= mmb_pkg::qmul(cv[2], cv[1]);
		szcx_s1 <= mmb_pkg::qmul(sv[2], cv[0]);
		szsx_s1 <= mmb_pkg::qmul(sv[2], sv[0]);
		szcy_s1 <= mmb_pkg::qmul(sv[2], cv[1]);
		czcx_s1 <= mmb_pkg::qmul(cv[2], cv[0]);
		czsx_s1 <= mmb_pkg::qmul(cv[2], sv[0]);
		cysx_s1 <= mmb_pkg::qmul(cv[1], sv[0]);
		cycx_s1 <= mmb_pkg::qmul(cv[1], cv[0]);
		sx_s1   <= sv[0];
		cx_s1   <= cv[0];
		nsy_s1  <= -sv[1];

		it_s2   <= it_s1;
		p1_s2   <= mmb_pkg::qmul(czsy_s1, sx_s1);
		p2_s2   <= mmb_pkg::qmul(czsy_s1, cx_s1);
		p3_s2   <= mmb_pkg::qmul(szsy_s1, sx_s1);
		p4_s2   <= mmb_pkg::qmul(szsy_s1, cx_s1);
		szcx_s2 <= szcx_s1;
		szsx_s2 <= szsx_s1;
		czcx_s2 <= czcx_s1;
		czsx_s2 <= czsx_s1;
		czcy_s2 <= czcy_s1;
		szcy_s2 <= szcy_s1;
		cysx_s2 <= cysx_s1;
		cycx_s2 <= cycx_s1;
		nsy_s2  <= nsy_s1;

		ent_s3.trans <= it_s2.trans;
		ent_s3.scale <= it_s2.scale;
		ent_s3.r[0]  <= czcy_s2;
		ent_s3.r[1]  <= p1_s2 - szcx_s2;
		ent_s3.r[2]  <= p2_s2 + szsx_s2;
		ent_s3.r[3]  <= szcy_s2;
		ent_s3.r[4]  <= p3_s2 + czcx_s2;
		ent_s3.r[5]  <= p4_s2 - czsx_s2;
		ent_s3.r[6]  <= nsy_s2;
		ent_s3.r[7]  <= cysx_s2;
		ent_s3.r[8]  <= cycx_s2;
	end

	assign out_valid = vm3_s3;
	assign out_entry = ent_s3;

endmodule

>>> hdl/mmb_queue.sv
module mmb_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mmb_pkg::entry_t     wr_entry,
	input  logic                pop,
	output logic                not_empty,
	output mmb_pkg::entry_t     rd_entry
);

	mmb_pkg::entry_t              mem_q [0:mmb_pkg::QDEPTH-1];
	logic [mmb_pkg::QAW-1:0]      wp_q, rp_q;
	logic [mmb_pkg::QCW-1:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + mmb_pkg::QCW'(push) - mmb_pkg::QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_entry;
		end
	end

	assign not_empty = cnt_q != '0;
	assign rd_entry  = mem_q[rp_q];

endmodule

>>> hdl/mmb_back.sv
module mmb_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ent_valid,
	input  mmb_pkg::entry_t            ent,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 out_col,
	output logic [3:0][mmb_pkg::DW-1:0] out_elem,
	output logic                       out_last
);

	localparam int RW = mmb_pkg::RW;
	localparam int DW = mmb_pkg::DW;
	localparam int PW = RW + DW;
	localparam logic [1:0] LAST_COL = 2'd3;

	logic                    adv;
	logic [1:0]              col_q;
	logic                    v_s1;
	logic [1:0]              col_s1;
	logic signed [PW-1:0]    prod_s1 [0:2];
	logic [2:0][DW-1:0]      tr_s1;
	logic signed [RW-1:0]    rsel [0:2];
	logic signed [PW-1:0]    rnd;
	logic signed [PW-1:0]    pr   [0:2];
	logic signed [PW-mmb_pkg::TRIG_FRAC-1:0] sh [0:2];
	logic [3:0][DW-1:0]      elem;

	assign adv = !out_valid || out_ready;
	assign pop = adv && ent_valid && (col_q == LAST_COL);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			unique case (col_q)
				2'd0:    rsel[r] = $signed(ent.r[r*3]);
				2'd1:    rsel[r] = $signed(ent.r[r*3+1]);
				2'd2:    rsel[r] = $signed(ent.r[r*3+2]);
				default: rsel[r] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= ent_valid;
			out_valid <= v_s1;
			if (ent_valid) begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1 <= col_q;
			tr_s1  <= ent.trans;
			for (int r = 0; r < 3; r++) begin
				prod_s1[r] <= rsel[r] * $signed(ent.scale);
			end
		end
	end

	always_comb begin
		rnd = '0;
		rnd[mmb_pkg::TRIG_FRAC-1] = 1'b1;
		elem = '0;
		for (int r = 0; r < 3; r++) begin
			pr[r] = prod_s1[r] + rnd;
			sh[r] = pr[r][PW-1:mmb_pkg::TRIG_FRAC];
			if (col_s1 == LAST_COL) begin
				elem[r] = tr_s1[r];
			end else if (sh[r] > $signed({{(PW-mmb_pkg::TRIG_FRAC-DW+1){1'b0}},
					{(DW-1){1'b1}}})) begin
				elem[r] = {1'b0, {(DW-1){1'b1}}};
			end else if (sh[r] < $signed({{(PW-mmb_pkg::TRIG_FRAC-DW+1){1'b1}},
					{(DW-1){1'b0}}})) begin
				elem[r] = {1'b1, {(DW-1){1'b0}}};
			end else begin
				elem[r] = sh[r][DW-1:0];
			end
		end
		if (col_s1 == LAST_COL) begin
			elem[3] = DW'(1) << mmb_pkg::FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_col  <= col_s1;
			out_elem <= elem;
			out_last <= col_s1 == LAST_COL;
		end
	end

endmodule

>>> hdl/model_matrix_builder_core.sv
// An accepted transaction passes the angle pipeline, the queue and the output
// stages to its column 0; the columns then follow one a cycle unless the output
// stalls, and this output port sets the throughput. The angle pipeline takes one
// item a cycle, while the credit allows, into a 16-entry queue.
// Reset clears all valid bits, the queue pointers and the credit count.
module model_matrix_builder_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// trans_x, trans_y, trans_z, angle_x_deg, angle_y_deg, angle_z_deg,
	// uniform_scale, zero pad
	input  logic [207:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// column_index, elem_row0, elem_row1, elem_row2, elem_row3, zero pad
	output logic [135:0] m_axis_tdata,
	output logic         m_axis_tlast
);

	mmb_pkg::item_t               item;
	mmb_pkg::entry_t              f_entry, q_entry;
	logic                         f_valid, q_ne, pop, acc;
	logic [mmb_pkg::QCW-1:0]      infl_q;
	logic [1:0]                   col;
	logic [3:0][mmb_pkg::DW-1:0]  elem;

	assign item.trans[0] = s_axis_tdata[31:0];
	assign item.trans[1] = s_axis_tdata[63:32];
	assign item.trans[2] = s_axis_tdata[95:64];
	assign item.angle[0] = s_axis_tdata[121:96];
	assign item.angle[1] = s_axis_tdata[147:122];
	assign item.angle[2] = s_axis_tdata[173:148];
	assign item.scale    = s_axis_tdata[205:174];

	assign s_axis_tready = infl_q != mmb_pkg::QCW'(mmb_pkg::QDEPTH);
	assign acc           = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q <= '0;
		end else begin
			infl_q <= infl_q + mmb_pkg::QCW'(acc) - mmb_pkg::QCW'(pop);
		end
	end

	mmb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (acc),
		.in_item   (item),
		.out_valid (f_valid),
		.out_entry (f_entry)
	);

	mmb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.wr_entry  (f_entry),
		.pop       (pop),
		.not_empty (q_ne),
		.rd_entry  (q_entry)
	);

	mmb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent_valid (q_ne),
		.ent       (q_entry),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_col   (col),
		.out_elem  (elem),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, elem[3], elem[2], elem[1], elem[0], col};

endmodule
